>>> rtl/lsu_pkg.sv
// Shared constants, field positions and controller/datapath command types of the load/store unit.
package lsu_pkg;

  localparam int unsigned XLEN    = 64;
  localparam int unsigned INSTR_W = 32;

  // Byte memory, split into eight byte-wide banks so that any 8-byte window
  // touches each bank at most once.
  localparam int unsigned MEM_BYTES  = 65536;
  localparam int unsigned NUM_BANKS  = 8;
  localparam int unsigned BANK_SEL_W = 3;
  localparam int unsigned MEM_ROWS   = MEM_BYTES / NUM_BANKS;
  localparam int unsigned ROW_W      = $clog2(MEM_ROWS);

  // Register file: 31 architectural registers plus the zero register slot.
  localparam int unsigned REG_SLOTS = 32;
  localparam int unsigned REG_IDX_W = 5;
  localparam logic [REG_IDX_W-1:0] ZERO_REG = 5'd31;

  // Instruction field positions.
  localparam int unsigned RT_LSB    = 0;
  localparam int unsigned RN_LSB    = 5;
  localparam int unsigned IMM9_BIT  = 10;
  localparam int unsigned PRE_BIT   = 11;
  localparam int unsigned IMM9_LSB  = 12;
  localparam int unsigned IMM9_W    = 9;
  localparam int unsigned IMM12_LSB = 10;
  localparam int unsigned IMM12_W   = 12;
  localparam int unsigned LOAD_BIT  = 22;
  localparam int unsigned UOFF_BIT  = 24;
  localparam int unsigned SIZE_BIT  = 30;

  // Highest legal start address for a 4-byte and an 8-byte transfer.
  localparam logic [XLEN-1:0] LIMIT_WORD  = XLEN'(MEM_BYTES - 4);
  localparam logic [XLEN-1:0] LIMIT_DWORD = XLEN'(MEM_BYTES - 8);

  typedef struct packed {
    logic accept;   // capture the instruction and read Rn and Rt
    logic calc;     // form the address, writeback value and range check
    logic mem_rd;   // read the bank rows of the access
    logic mem_wr;   // write the store bytes
    logic wb_base;  // write the updated base into Rn
    logic wb_rt;    // write the load data into Rt
    logic push;     // load the output register
    logic clr;      // clear one memory row
  } lsu_cmd_t;

  typedef struct packed {
    logic form_ok;
    logic fault;
    logic is_load;
    logic do_wb;
    logic clr_last;
  } lsu_sts_t;

endpackage

>>> rtl/lsu_if.sv
// Valid/ready channel interfaces for the instruction input and the result output.
interface lsu_in_if import lsu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INSTR_W-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface lsu_out_if import lsu_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [XLEN-1:0] eff_address;
  logic [XLEN-1:0] xfer_data;
  logic            was_load;
  logic            fault;

  modport source (output valid, output eff_address, output xfer_data, output was_load,
                  output fault, input ready);
  modport sink (input valid, input eff_address, input xfer_data, input was_load,
                input fault, output ready);
endinterface

>>> rtl/lsu_mem.sv
// Byte-banked data memory with unaligned 4/8-byte access and a row-by-row clearing pass.
module lsu_mem import lsu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic                  rd_i,
  input  logic                  wr_i,
  input  logic                  wide_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [BANK_SEL_W-1:0] lo_i,
  input  logic [XLEN-1:0]       wdata_i,
  output logic [XLEN-1:0]       rdata_o,
  output logic                  clr_last_o
);

  logic [ROW_W-1:0] clr_row_q, clr_row_d;
  logic [7:0]       bank_rd [NUM_BANKS];

  assign clr_row_d  = clr_i ? clr_row_q + 1'b1 : clr_row_q;
  assign clr_last_o = (clr_row_q == ROW_W'(MEM_ROWS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q <= '0;
    end else begin
      clr_row_q <= clr_row_d;
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [7:0]            bank_mem [MEM_ROWS];
    logic [7:0]            rd_q;
    logic [BANK_SEL_W-1:0] byte_idx;
    logic [ROW_W-1:0]      row;
    logic                  we;

    // Banks below the start offset hold the bytes that spill into the next row.
    always_comb begin
      byte_idx = BANK_SEL_W'(b) - lo_i;
      row      = (BANK_SEL_W'(b) >= lo_i) ? row_i : row_i + 1'b1;
      we       = wr_i && (!byte_idx[BANK_SEL_W-1] || wide_i);
    end

    always_ff @(posedge clk_i) begin
      if (clr_i) begin
        bank_mem[clr_row_q] <= '0;
      end else if (we) begin
        bank_mem[row] <= wdata_i[{byte_idx, 3'b000} +: 8];
      end
      if (rd_i) begin
        rd_q <= bank_mem[row];
      end
    end

    assign bank_rd[b] = rd_q;
  end

  always_comb begin
    rdata_o = '0;
    for (int i = 0; i < NUM_BANKS; i++) begin
      rdata_o[i*8 +: 8] = bank_rd[BANK_SEL_W'(i) + lo_i];
    end
  end

endmodule

>>> rtl/lsu_datapath.sv
// Datapath: register file, address generation, range check, data memory and result register.
module lsu_datapath import lsu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsu_cmd_t           cmd_i,
  output lsu_sts_t           sts_o,
  input  logic [INSTR_W-1:0] instr_i,
  output logic [XLEN-1:0]    eff_address_o,
  output logic [XLEN-1:0]    xfer_data_o,
  output logic               was_load_o,
  output logic               fault_o
);

  logic [INSTR_W-1:0]   instr_q;
  logic [XLEN-1:0]      rf_mem [REG_SLOTS];
  logic [REG_SLOTS-1:0] rf_vld_q, rf_vld_d;
  logic [XLEN-1:0]      base_q, rtv_q;
  logic                 base_vld_q, rtv_vld_q;
  logic [XLEN-1:0]      addr_q, wb_q;
  logic                 fault_q, form_q;
  logic [XLEN-1:0]      eff_address_q, xfer_data_q;
  logic                 was_load_q, out_fault_q;

  logic [REG_IDX_W-1:0] rt, rn, rt_in, rn_in;
  logic                 is_load, wide, uoff, pre;
  logic [XLEN-1:0]      base, rt_val, off12, off9, sum, addr_d;
  logic                 fault_d, form_d;
  logic [XLEN-1:0]      st_data, ld_raw, ld_data;
  logic                 mem_clr_last;

  assign rt_in   = instr_i[RT_LSB +: REG_IDX_W];
  assign rn_in   = instr_i[RN_LSB +: REG_IDX_W];
  assign rt      = instr_q[RT_LSB +: REG_IDX_W];
  assign rn      = instr_q[RN_LSB +: REG_IDX_W];
  assign is_load = instr_q[LOAD_BIT];
  assign wide    = instr_q[SIZE_BIT];
  assign uoff    = instr_q[UOFF_BIT];
  assign pre     = instr_q[PRE_BIT];

  assign base   = base_vld_q ? base_q : '0;
  assign rt_val = rtv_vld_q ? rtv_q : '0;

  always_comb begin
    off12 = XLEN'(instr_q[IMM12_LSB +: IMM12_W]) << (wide ? 3 : 2);
    off9  = {{(XLEN-IMM9_W){instr_q[IMM9_LSB+IMM9_W-1]}}, instr_q[IMM9_LSB +: IMM9_W]};
    sum   = base + (uoff ? off12 : off9);
    // Post-index accesses the old base; the sum only goes back into Rn.
    addr_d  = (uoff || pre) ? sum : base;
    form_d  = uoff || instr_q[IMM9_BIT];
    fault_d = addr_d > (wide ? LIMIT_DWORD : LIMIT_WORD);
  end

  assign st_data = wide ? rt_val : {32'b0, rt_val[31:0]};
  assign ld_data = wide ? ld_raw : {32'b0, ld_raw[31:0]};

  // Register file: read at the transfer of the instruction, one write per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      instr_q    <= instr_i;
      base_q     <= rf_mem[rn_in];
      rtv_q      <= rf_mem[rt_in];
      base_vld_q <= rf_vld_q[rn_in];
      rtv_vld_q  <= rf_vld_q[rt_in];
    end
    if (cmd_i.wb_base && rn != ZERO_REG) begin
      rf_mem[rn] <= wb_q;
    end else if (cmd_i.wb_rt && rt != ZERO_REG) begin
      rf_mem[rt] <= ld_data;
    end
  end

  always_comb begin
    rf_vld_d = rf_vld_q;
    if (cmd_i.wb_base && rn != ZERO_REG) begin
      rf_vld_d[rn] = 1'b1;
    end else if (cmd_i.wb_rt && rt != ZERO_REG) begin
      rf_vld_d[rt] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else begin
      rf_vld_q <= rf_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      addr_q  <= addr_d;
      wb_q    <= sum;
      fault_q <= fault_d;
      form_q  <= form_d;
    end
    if (cmd_i.push) begin
      eff_address_q <= form_q ? addr_q : '0;
      xfer_data_q   <= (!form_q || fault_q) ? '0 : (is_load ? ld_data : st_data);
      was_load_q    <= form_q && is_load;
      out_fault_q   <= form_q && fault_q;
    end
  end

  lsu_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cmd_i.clr),
    .rd_i       (cmd_i.mem_rd),
    .wr_i       (cmd_i.mem_wr),
    .wide_i     (wide),
    .row_i      (addr_q[BANK_SEL_W +: ROW_W]),
    .lo_i       (addr_q[BANK_SEL_W-1:0]),
    .wdata_i    (st_data),
    .rdata_o    (ld_raw),
    .clr_last_o (mem_clr_last)
  );

  always_comb begin
    sts_o.form_ok  = form_q;
    sts_o.fault    = fault_q;
    sts_o.is_load  = is_load;
    sts_o.do_wb    = !uoff;
    sts_o.clr_last = mem_clr_last;
  end

  assign eff_address_o = eff_address_q;
  assign xfer_data_o   = xfer_data_q;
  assign was_load_o    = was_load_q;
  assign fault_o       = out_fault_q;

endmodule

>>> rtl/lsu_ctrl.sv
// Controller: sequences clearing, address, memory and register-writeback steps per instruction.
module lsu_ctrl import lsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  lsu_sts_t sts_i,
  output lsu_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_MEM   = 3'd3;
  localparam logic [2:0] S_LDW   = 3'd4;
  localparam logic [2:0] S_WBT   = 3'd5;
  localparam logic [2:0] S_WBN   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.calc = 1'b1;
        state_d    = S_MEM;
      end
      S_MEM: begin
        if (!sts_i.form_ok || sts_i.fault) begin
          state_d = S_DONE;
        end else if (sts_i.is_load) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = S_LDW;
        end else begin
          cmd_o.mem_wr = 1'b1;
          state_d      = sts_i.do_wb ? S_WBN : S_DONE;
        end
      end
      S_LDW: begin
        // Base writeback goes first so that a load into Rn keeps the loaded value.
        if (sts_i.do_wb) begin
          cmd_o.wb_base = 1'b1;
          state_d       = S_WBT;
        end else begin
          cmd_o.wb_rt = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_WBT: begin
        cmd_o.wb_rt = 1'b1;
        state_d     = S_DONE;
      end
      S_WBN: begin
        cmd_o.wb_base = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.push ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/load_store_unit.sv
// Load/store unit top level: executes single-data-transfer words against registers and memory.
//
// Instructions arrive on the in_i channel (valid/ready, one 32-bit word per
// transfer); one result per instruction leaves on the out_o channel with the
// access address, the data moved, the load flag and the fault flag.
// Instructions are executed one at a time. After the input transfer each one
// passes an address and a memory state; a fault, an unsupported form or a store
// without writeback then goes to the done state, a store with writeback first
// writes Rn, and a load writes Rn (with writeback) and then Rt. A new instruction
// is taken the cycle after the result is loaded. The steps follow from the single
// register-file write port and the registered read of the memory banks.
// The result sits in an output register, so the next instruction is taken
// while a result waits; a stalled receiver only holds the unit once the
// following result is ready to be loaded.
// After reset the data memory is cleared one 8-byte row per cycle, all
// MEM_BYTES/8 rows (8192 at 64 KiB); in_i.ready stays low during that pass.
// Registers read as zero after reset, and register 31 always reads as zero.
module load_store_unit import lsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsu_in_if.sink    in_i,
  lsu_out_if.source out_o
);

  lsu_cmd_t cmd;
  lsu_sts_t sts;

  lsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lsu_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .instr_i       (in_i.instr_word),
    .eff_address_o (out_o.eff_address),
    .xfer_data_o   (out_o.xfer_data),
    .was_load_o    (out_o.was_load),
    .fault_o       (out_o.fault)
  );

  // A faulting transfer moves no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.fault |-> out_o.xfer_data == '0)
    else $error("fault result carries data");

  // Every non-faulting result lies inside the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.fault |-> out_o.eff_address <= LIMIT_WORD)
    else $error("non-faulting access outside memory");

  // A new instruction is never taken while a register is written or the memory is cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> !(cmd.wb_base || cmd.wb_rt || cmd.clr))
    else $error("instruction taken during register write or clearing");

  // The output register is only reloaded when its previous result has gone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !out_o.valid || out_o.ready)
    else $error("result overwritten before transfer");

endmodule

>>> dv/tb_load_store_unit.sv
// Self-checking testbench for the load/store unit: directed table, then random instruction words.
`timescale 1ns / 100ps

module tb_load_store_unit;
  import lsu_pkg::*;

  typedef struct packed {
    logic [XLEN-1:0] eff_address;
    logic [XLEN-1:0] xfer_data;
    logic            was_load;
    logic            fault;
  } ldst_res_t;

  typedef struct {
    logic [INSTR_W-1:0] word;
    bit                 typed;
    ldst_res_t          want;
  } dir_row_t;

  localparam ldst_res_t NO_RES = '0;
  localparam int unsigned RAND_ITEMS = 1528;

  logic clk_i;
  logic rst_ni;

  lsu_in_if  in_if ();
  lsu_out_if out_if ();

  load_store_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the architectural state; slot 31 is never written.
  logic [XLEN-1:0] gpr_img [REG_SLOTS];
  logic [7:0]      mem_img [MEM_BYTES];

  ldst_res_t   result_q [$];
  dir_row_t    dir_tbl [$];
  int unsigned mism_cnt;
  int unsigned burst_left;
  int unsigned n_load, n_store, n_fault, n_unsup, n_wb;
  int unsigned rcv_left;
  int unsigned rcv_mode;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [INSTR_W-1:0] uoff_word(input bit ld, input bit wide,
                                                   input logic [IMM12_W-1:0] imm12,
                                                   input logic [4:0] rn, input logic [4:0] rt);
    logic [INSTR_W-1:0] w;
    w = '0;
    w[UOFF_BIT] = 1'b1;
    w[SIZE_BIT] = wide;
    w[LOAD_BIT] = ld;
    w[IMM12_LSB +: IMM12_W] = imm12;
    w[RN_LSB +: REG_IDX_W]  = rn;
    w[RT_LSB +: REG_IDX_W]  = rt;
    return w;
  endfunction

  function automatic logic [INSTR_W-1:0] idx_word(input bit ld, input bit wide, input bit pre,
                                                  input int imm9, input logic [4:0] rn,
                                                  input logic [4:0] rt);
    logic [INSTR_W-1:0] w;
    w = '0;
    w[IMM9_BIT] = 1'b1;
    w[PRE_BIT]  = pre;
    w[SIZE_BIT] = wide;
    w[LOAD_BIT] = ld;
    w[IMM9_LSB +: IMM9_W]  = IMM9_W'(imm9);
    w[RN_LSB +: REG_IDX_W] = rn;
    w[RT_LSB +: REG_IDX_W] = rt;
    return w;
  endfunction

  // Executes one word against the shadow state and returns the result it must produce.
  function automatic ldst_res_t exec_ldst(input logic [INSTR_W-1:0] w);
    logic [REG_IDX_W-1:0] rt, rn;
    logic                 ld, wide, do_wb;
    logic [XLEN-1:0]      base, addr, wb_val, data, nbytes;
    int unsigned          a;
    ldst_res_t            r;
    r      = '0;
    rt     = w[RT_LSB +: REG_IDX_W];
    rn     = w[RN_LSB +: REG_IDX_W];
    ld     = w[LOAD_BIT];
    wide   = w[SIZE_BIT];
    nbytes = wide ? 64'd8 : 64'd4;
    base   = gpr_img[rn];
    wb_val = '0;
    data   = '0;
    if (w[UOFF_BIT]) begin
      addr  = base + (XLEN'(w[IMM12_LSB +: IMM12_W]) << (wide ? 3 : 2));
      do_wb = 1'b0;
    end else if (w[IMM9_BIT]) begin
      wb_val = base + {{(XLEN-IMM9_W){w[IMM9_LSB+IMM9_W-1]}}, w[IMM9_LSB +: IMM9_W]};
      do_wb  = 1'b1;
      addr   = w[PRE_BIT] ? wb_val : base;
    end else begin
      n_unsup++;
      return r;
    end
    r.eff_address = addr;
    r.was_load    = ld;
    if (addr > XLEN'(MEM_BYTES) - nbytes) begin
      r.fault = 1'b1;
      n_fault++;
      return r;
    end
    a = addr[31:0];
    if (ld) begin
      for (int i = 0; i < int'(nbytes); i++) data |= XLEN'(mem_img[a + i]) << (8 * i);
      if (do_wb && rn != ZERO_REG) gpr_img[rn] = wb_val;
      // On a clash between Rt and Rn the loaded value is written last and wins.
      if (rt != ZERO_REG) gpr_img[rt] = data;
      n_load++;
    end else begin
      data = gpr_img[rt];
      if (!wide) data[63:32] = '0;
      for (int i = 0; i < int'(nbytes); i++) mem_img[a + i] = data[8*i +: 8];
      if (do_wb && rn != ZERO_REG) gpr_img[rn] = wb_val;
      n_store++;
    end
    if (do_wb) n_wb++;
    r.xfer_data = data;
    return r;
  endfunction

  // Mostly well-formed accesses whose base lies inside memory, plus some noise.
  function automatic logic [INSTR_W-1:0] pick_word();
    logic [INSTR_W-1:0] w;
    logic [4:0]         rn;
    int unsigned        mode;
    mode = $urandom_range(0, 99);
    if (mode < 8) return $urandom;
    if (mode < 12) begin
      w = $urandom;
      w[UOFF_BIT] = 1'b0;
      w[IMM9_BIT] = 1'b0;
      return w;
    end
    rn = 5'($urandom_range(0, 31));
    for (int k = 0; k < 6 && gpr_img[rn] >= XLEN'(MEM_BYTES); k++) rn = 5'($urandom_range(0, 31));
    if (gpr_img[rn] >= XLEN'(MEM_BYTES)) rn = ZERO_REG;
    if ($urandom_range(0, 1))
      w = uoff_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 63)) : 12'($urandom),
                    rn, 5'($urandom_range(0, 31)));
    else
      w = idx_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)),
                   int'($urandom_range(0, 511)), rn, 5'($urandom_range(0, 31)));
    // Bits the unit ignores carry random values.
    w[31]    = 1'($urandom_range(0, 1));
    w[29:25] = 5'($urandom);
    w[23]    = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_instr(input logic [INSTR_W-1:0] w, input bit typed, input ldst_res_t want);
    ldst_res_t pred;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_if.valid      <= 1'b1;
    in_if.instr_word <= w;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pred = exec_ldst(w);
    result_q.push_back(typed ? want : pred);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (result_q.size() != 0);
  endtask

  // The receiver switches between always ready, coin flips and rare acceptance.
  always @(negedge clk_i) begin
    if (rcv_left == 0) begin
      rcv_mode <= $urandom_range(0, 2);
      rcv_left <= $urandom_range(16, 96);
    end else begin
      rcv_left <= rcv_left - 1;
    end
    case (rcv_mode)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_if.ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  always @(posedge clk_i) begin : result_check
    ldst_res_t got, want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.eff_address, out_if.xfer_data, out_if.was_load, out_if.fault};
      if (result_q.size() == 0) begin
        if (mism_cnt < 10) $display("ERROR: unexpected result addr=%h data=%h load=%b fault=%b",
                                    got.eff_address, got.xfer_data, got.was_load, got.fault);
        mism_cnt++;
      end else begin
        want = result_q.pop_front();
        if (got.eff_address !== want.eff_address || got.xfer_data !== want.xfer_data ||
            got.was_load !== want.was_load || got.fault !== want.fault) begin
          if (mism_cnt < 10) begin
            $display("ERROR: mismatch at %0t", $realtime);
            $display("  addr  exp %h got %h", want.eff_address, got.eff_address);
            $display("  data  exp %h got %h", want.xfer_data, got.xfer_data);
            $display("  load  exp %b got %b  fault exp %b got %b",
                     want.was_load, got.was_load, want.fault, got.fault);
          end
          mism_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.instr_word = '0;
    out_if.ready     = 1'b0;
    rcv_left         = 0;
    rcv_mode         = 0;
    burst_left       = 0;
    mism_cnt         = 0;
    foreach (gpr_img[i]) gpr_img[i] = '0;
    foreach (mem_img[i]) mem_img[i] = '0;

    // Each row builds on the state left by the rows above it.
    dir_tbl.push_back('{uoff_word(1, 1, 12'h000, 31, 1), 1'b1, '{64'h0, 64'h0, 1'b1, 1'b0}});
    dir_tbl.push_back('{32'h4040_0043, 1'b1, NO_RES});
    dir_tbl.push_back('{idx_word(0, 1, 0, -256, 0, 0), 1'b0, NO_RES});
    dir_tbl.push_back('{idx_word(0, 1, 1, -8, 0, 0), 1'b1,
                        '{64'hFFFF_FFFF_FFFF_FEF8, 64'h0, 1'b0, 1'b1}});
    dir_tbl.push_back('{uoff_word(0, 0, 12'h048, 0, 0), 1'b0, NO_RES});
    dir_tbl.push_back('{idx_word(1, 0, 1, 34, 31, 4), 1'b0, NO_RES});
    dir_tbl.push_back('{idx_word(0, 1, 1, -7, 4, 0), 1'b0, NO_RES});
    dir_tbl.push_back('{uoff_word(1, 1, 12'h000, 4, 5), 1'b0, NO_RES});
    dir_tbl.push_back('{idx_word(1, 1, 1, 1, 4, 6), 1'b1, '{64'd65529, 64'h0, 1'b1, 1'b1}});
    dir_tbl.push_back('{idx_word(1, 0, 1, 4, 4, 6), 1'b0, NO_RES});
    dir_tbl.push_back('{idx_word(0, 0, 1, 1, 4, 6), 1'b1, '{64'd65533, 64'h0, 1'b0, 1'b1}});
    dir_tbl.push_back('{idx_word(1, 1, 0, -256, 4, 7), 1'b1, '{64'd65532, 64'h0, 1'b1, 1'b1}});
    dir_tbl.push_back('{idx_word(1, 0, 0, -4, 4, 4), 1'b0, NO_RES});
    dir_tbl.push_back('{idx_word(0, 1, 0, 255, 1, 1), 1'b0, NO_RES});
    dir_tbl.push_back('{idx_word(0, 1, 0, -128, 1, 1), 1'b0, NO_RES});
    dir_tbl.push_back('{uoff_word(0, 1, 12'hFFF, 31, 5), 1'b0, NO_RES});
    dir_tbl.push_back('{uoff_word(1, 0, 12'hFFF, 31, 8), 1'b0, NO_RES});
    dir_tbl.push_back('{uoff_word(1, 1, 12'h040, 5, 9), 1'b0, NO_RES});
    dir_tbl.push_back('{uoff_word(1, 1, 12'h001, 4, 10), 1'b1,
                        '{64'h1_0000_0007, 64'h0, 1'b1, 1'b1}});
    dir_tbl.push_back('{32'hFEFF_FBFF, 1'b1, NO_RES});
    dir_tbl.push_back('{32'hFFFF_FFFF, 1'b0, NO_RES});
    dir_tbl.push_back('{32'h0000_0000, 1'b1, NO_RES});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i]) send_instr(dir_tbl[i].word, dir_tbl[i].typed, dir_tbl[i].want);
    drain_results();

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      // Hold off once in the middle until every result has come back.
      if (n == RAND_ITEMS / 2) drain_results();
      send_instr(pick_word(), 1'b0, NO_RES);
    end
    in_if.valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d loads and %0d stores, %0d with base writeback.",
             n_load, n_store, n_wb);
    $display("Also %0d out-of-range accesses and %0d unsupported forms; %0d mismatches.",
             n_fault, n_unsup, mism_cnt);
    if (mism_cnt == 0 && result_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("ERROR: timeout, %0d results still outstanding", result_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
rtl/lsu_pkg.sv
rtl/lsu_if.sv
rtl/lsu_mem.sv
rtl/lsu_datapath.sv
rtl/lsu_ctrl.sv
rtl/load_store_unit.sv
dv/tb_load_store_unit.sv
